[hw/rtl/nopt_pkg.sv]
`timescale 1ns / 1ps

package nopt_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic FUNC_ON  = 1'b0;
    localparam logic FUNC_OFF = 1'b1;

    typedef enum logic [1:0] {
        STATUS_STORED  = 2'd0,
        STATUS_DONE    = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_NOMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic        func;
        logic [3:0]  pitch_class;
        logic [3:0]  octave;
        logic [6:0]  velocity;
        logic [31:0] event_tick;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  done_pitch_class;
        logic [3:0]  done_octave;
        logic [6:0]  done_velocity;
        logic [31:0] start_tick;
        logic [31:0] end_tick;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  pitch;
        logic [3:0]  octave;
        logic [6:0]  velocity;
        logic [31:0] start;
    } slot_entry_t;

    // One write into the table: active bit always, entry data on load.
    typedef struct packed {
        logic                  en;
        logic                  active;
        logic                  load;
        logic [SLOT_IDX_W-1:0] idx;
        slot_entry_t           entry;
    } slot_wr_t;

endpackage

[hw/rtl/nopt_slot_table.sv]
`timescale 1ns / 1ps

module nopt_slot_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [nopt_pkg::SLOT_IDX_W-1:0] rd_idx,
    output logic                           rd_active,
    output nopt_pkg::slot_entry_t          rd_entry,
    input  nopt_pkg::slot_wr_t             wr
);
    import nopt_pkg::*;

    logic [SLOT_COUNT-1:0] active_reg;
    slot_entry_t           entry_reg [SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (wr.en)
        begin
            active_reg[wr.idx] <= wr.active;
        end
    end

    // Entry data is only ever read from active slots, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.load)
        begin
            entry_reg[wr.idx] <= wr.entry;
        end
    end

    assign rd_active = active_reg[rd_idx];
    assign rd_entry  = entry_reg[rd_idx];

endmodule

[hw/rtl/note_on_off_pairing_table.sv]
`timescale 1ns / 1ps

// Pairs note-on and note-off items into completed notes using a table of
// SLOT_COUNT slots (16). Every input item gives exactly one result item. The
// block takes an item when idle, then checks one slot per cycle with a single
// compare unit, starting at slot 0 and stopping at the first free slot
// (note-on) or the first active slot of the same pitch class and octave
// (note-off, or note-on with velocity zero). A full table or a missing match
// ends the search at the last slot. in_stall is high during the search and
// while a finished result cannot enter the output register. The output
// register lets the next item be accepted while a result still waits.
module note_on_off_pairing_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nopt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output nopt_pkg::out_item_t out_data
);
    import nopt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    in_item_t              item_reg;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;

    logic        rd_active;
    slot_entry_t rd_entry;
    slot_wr_t    wr;

    logic in_take;
    logic is_on;
    logic hit;
    logic last;
    logic finish;
    logic commit;

    nopt_slot_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (idx_reg),
        .rd_active (rd_active),
        .rd_entry  (rd_entry),
        .wr        (wr)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    assign is_on  = (item_reg.func == FUNC_ON) && (item_reg.velocity != 7'd0);
    assign hit    = is_on ? !rd_active
                          : (rd_active && (rd_entry.pitch == item_reg.pitch_class)
                                       && (rd_entry.octave == item_reg.octave));
    assign last   = (idx_reg == SLOT_IDX_W'(SLOT_COUNT - 1));
    assign finish = (state_reg == ST_SCAN) && (hit || last);
    assign commit = finish && (!out_valid_reg || !out_stall);

    always_comb
    begin
        wr.en             = commit && hit;
        wr.active         = is_on;
        wr.load           = is_on;
        wr.idx            = idx_reg;
        wr.entry.pitch    = item_reg.pitch_class;
        wr.entry.octave   = item_reg.octave;
        wr.entry.velocity = item_reg.velocity;
        wr.entry.start    = item_reg.event_tick;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (!finish)
                begin
                    idx_next = idx_reg + SLOT_IDX_W'(1);
                end
                else if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (hit && is_on)
                    begin
                        out_next.status = STATUS_STORED;
                    end
                    else if (hit)
                    begin
                        out_next.status           = STATUS_DONE;
                        out_next.done_pitch_class = item_reg.pitch_class;
                        out_next.done_octave      = item_reg.octave;
                        out_next.done_velocity    = rd_entry.velocity;
                        out_next.start_tick       = rd_entry.start;
                        out_next.end_tick         = item_reg.event_tick;
                    end
                    else if (is_on)
                    begin
                        out_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        out_next.status = STATUS_NOMATCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
